@@ rtl/spq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Types, codes and sizes shared by the stable priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH     = 16;
	localparam int TAG_BITS  = 16;
	localparam int PRIO_BITS = 2;
	localparam int OCC_BITS  = $clog2(DEPTH + 1);

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_POP    = 1'b1;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_POPPED   = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic                 mode;
		logic [TAG_BITS-1:0]  tag;
		logic [PRIO_BITS-1:0] priority_req;
	} req_item_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [TAG_BITS-1:0]  out_tag;
		logic [PRIO_BITS-1:0] out_priority;
		logic [OCC_BITS-1:0]  occupancy;
	} rsp_item_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} spq_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} spq_stat_t;

endpackage

`default_nettype wire

@@ rtl/spq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: takes a request, runs one datapath update, holds the response.
// ----------------------------------------------------------------------------
module spq_ctrl
	import spq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	input  wire spq_stat_t stat,
	output spq_cmd_t       cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       unused_stat;

	assign unused_stat = stat.empty ^ stat.full;

	always_comb begin
		state_d     = state_q;
		req_stall   = 1'b1;
		rsp_valid   = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.execute = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				rsp_valid = 1'b1;
				if (!rsp_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/spq_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_dp
// Row of sorted entry cells; each cell compares and shifts with its neighbour.
// ----------------------------------------------------------------------------
module spq_dp
	import spq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire req_item_t req,
	input  wire spq_cmd_t  cmd,
	output spq_stat_t      stat,
	output rsp_item_t      rsp
);

	req_item_t            req_q;
	rsp_item_t            rsp_q;
	logic [OCC_BITS-1:0]  count_q;
	logic [TAG_BITS-1:0]  tag_q  [DEPTH];
	logic [PRIO_BITS-1:0] prio_q [DEPTH];
	logic [DEPTH-1:0]     keep;
	logic [DEPTH-1:0]     keep_sh;
	logic                 insert_ok;
	logic                 pop_ok;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == OCC_BITS'(DEPTH));
	assign insert_ok  = (req_q.mode == MODE_INSERT) && !stat.full;
	assign pop_ok     = (req_q.mode == MODE_POP) && !stat.empty;
	assign keep_sh    = {keep[DEPTH-2:0], 1'b1};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [TAG_BITS-1:0]  tag_d;
		logic [PRIO_BITS-1:0] prio_d;

		assign keep[i] = (OCC_BITS'(i) < count_q) && (prio_q[i] >= req_q.priority_req);

		always_comb begin
			tag_d  = tag_q[i];
			prio_d = prio_q[i];
			if (insert_ok) begin
				if (!keep[i] && keep_sh[i]) begin
					tag_d  = req_q.tag;
					prio_d = req_q.priority_req;
				end else if (!keep[i]) begin
					if (i > 0) begin
						tag_d  = tag_q[(i > 0) ? i - 1 : 0];
						prio_d = prio_q[(i > 0) ? i - 1 : 0];
					end
				end
			end else if (pop_ok) begin
				if (i < DEPTH - 1) begin
					tag_d  = tag_q[(i < DEPTH - 1) ? i + 1 : i];
					prio_d = prio_q[(i < DEPTH - 1) ? i + 1 : i];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.execute) begin
				tag_q[i]  <= tag_d;
				prio_q[i] <= prio_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.execute) begin
			if (insert_ok) begin
				count_q <= count_q + OCC_BITS'(1);
			end else if (pop_ok) begin
				count_q <= count_q - OCC_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			rsp_q.out_tag      <= '0;
			rsp_q.out_priority <= '0;
			if (req_q.mode == MODE_INSERT) begin
				if (stat.full) begin
					rsp_q.status    <= ST_FULL;
					rsp_q.occupancy <= count_q;
				end else begin
					rsp_q.status    <= ST_INSERTED;
					rsp_q.occupancy <= count_q + OCC_BITS'(1);
				end
			end else begin
				if (stat.empty) begin
					rsp_q.status    <= ST_EMPTY;
					rsp_q.occupancy <= count_q;
				end else begin
					rsp_q.status       <= ST_POPPED;
					rsp_q.out_tag      <= tag_q[0];
					rsp_q.out_priority <= prio_q[0];
					rsp_q.occupancy    <= count_q - OCC_BITS'(1);
				end
			end
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

@@ rtl/stable_priority_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue, highest priority first, FIFO among equal priorities.
// Sequence: capture, update and response steps of the sequencer, the whole
// entry row shifting in one update; the response is held until taken,
// and a new request is accepted only after the response has been taken.
// Reset: arst_n clears the sequencer and the entry count; queue starts empty.
// ----------------------------------------------------------------------------
module stable_priority_queue
	import spq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire req_item_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_item_t      rsp
);

	spq_cmd_t  cmd;
	spq_stat_t stat;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	spq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire
